FILE: src/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared widths, register indexes and pipeline payload types for the
// ray / plane intersection block.
// ----------------------------------------------------------------------------
package rpi_pkg;

  // Field widths
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MAT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Arithmetic widths: 32x32 products, a sum of four of them, and a
  // 31-bit quotient (t is never negative, so the sign bit is dropped)
  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned MAG_W  = PROD_W;
  localparam int unsigned T_W    = COORD_W - 1;
  localparam int unsigned DIV_W  = MAG_W + T_W;

  localparam logic [T_W-1:0] T_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATERIAL_ID  = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } rpi_vec_t;

  typedef struct packed {
    rpi_vec_t           normal;
    logic [COORD_W-1:0] plane_offset;
    logic [MAT_W-1:0]   material_id;
  } rpi_cfg_t;

  // Per-ray values that ride along until the final range checks
  typedef struct packed {
    logic [COORD_W-1:0] min_t;
    logic               prior_valid;
    logic [COORD_W-1:0] prior_t;
  } rpi_side_t;

  // Divider stage payload
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [T_W-1:0]   quo;
    logic             sat;
    logic             reject;
    rpi_side_t        side;
  } rpi_div_t;

endpackage

FILE: src/rpi_dot.sv
// ----------------------------------------------------------------------------
// rpi_dot
// Three-stage numerator / denominator datapath: six 32x32 products, then
// two levels of adders giving the exact signed sums.
// ----------------------------------------------------------------------------
module rpi_dot
  import rpi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rpi_vec_t              origin_i,
  input  rpi_vec_t              dir_i,
  input  rpi_side_t             side_i,
  input  rpi_cfg_t              cfg_i,
  output logic                  valid_o,
  output logic signed [SUM_W-1:0] num_o,
  output logic signed [SUM_W-1:0] den_o,
  output rpi_side_t             side_o
);

  logic [2:0] valid_q;

  // Signed views of the operands
  logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz, nx, ny, nz, off;
  assign ox  = origin_i.x;
  assign oy  = origin_i.y;
  assign oz  = origin_i.z;
  assign dx  = dir_i.x;
  assign dy  = dir_i.y;
  assign dz  = dir_i.z;
  assign nx  = cfg_i.normal.x;
  assign ny  = cfg_i.normal.y;
  assign nz  = cfg_i.normal.z;
  assign off = cfg_i.plane_offset;

  // Stage 1: products
  logic signed [PROD_W-1:0] po_x_d, po_y_d, po_z_d, pd_x_d, pd_y_d, pd_z_d, off_d;
  logic signed [PROD_W-1:0] po_x_q, po_y_q, po_z_q, pd_x_q, pd_y_q, pd_z_q, off_q;
  rpi_side_t                side1_q, side2_q, side3_q;

  always_comb begin
    po_x_d = ox * nx;
    po_y_d = oy * ny;
    po_z_d = oz * nz;
    pd_x_d = dx * nx;
    pd_y_d = dy * ny;
    pd_z_d = dz * nz;
    off_d  = PROD_W'(off) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      po_x_q  <= po_x_d;
      po_y_q  <= po_y_d;
      po_z_q  <= po_z_d;
      pd_x_q  <= pd_x_d;
      pd_y_q  <= pd_y_d;
      pd_z_q  <= pd_z_d;
      off_q   <= off_d;
      side1_q <= side_i;
    end
  end

  // Stage 2: first adder level
  logic signed [SUM_W-1:0] num_a_d, num_b_d, den_a_d, den_b_d;
  logic signed [SUM_W-1:0] num_a_q, num_b_q, den_a_q, den_b_q;

  always_comb begin
    num_a_d = SUM_W'(off_q) - SUM_W'(po_x_q);
    num_b_d = SUM_W'(po_y_q) + SUM_W'(po_z_q);
    den_a_d = SUM_W'(pd_x_q) + SUM_W'(pd_y_q);
    den_b_d = SUM_W'(pd_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q <= num_a_d;
      num_b_q <= num_b_d;
      den_a_q <= den_a_d;
      den_b_q <= den_b_d;
      side2_q <= side1_q;
    end
  end

  // Stage 3: final sums
  logic signed [SUM_W-1:0] num_d, den_d, num_q, den_q;

  always_comb begin
    num_d = num_a_q - num_b_q;
    den_d = den_a_q + den_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      den_q   <= den_d;
      side3_q <= side2_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o = valid_q[2];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side3_q;

endmodule

FILE: src/rpi_div_step.sv
// ----------------------------------------------------------------------------
// rpi_div_step
// One restoring-division stage: settles one quotient bit with a single
// wide compare and subtract, then registers the partial result.
// ----------------------------------------------------------------------------
module rpi_div_step
  import rpi_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  rpi_div_t data_i,
  output logic     valid_o,
  output rpi_div_t data_o
);

  logic             valid_q;
  rpi_div_t         data_d, data_q;
  logic [DIV_W-1:0] trial;
  logic             fits;

  // Trial subtract of the divisor aligned to this quotient bit
  always_comb begin
    trial          = DIV_W'(data_i.den) << BIT;
    fits           = !data_i.sat && (data_i.rem >= trial);
    data_d         = data_i;
    data_d.quo[BIT] = fits;
    if (fits) begin
      data_d.rem = data_i.rem - trial;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/rpi_div.sv
// ----------------------------------------------------------------------------
// rpi_div
// Signed sums to saturated unsigned quotient: magnitude and reject flags,
// saturation check, then one pipeline stage per quotient bit.
// ----------------------------------------------------------------------------
module rpi_div
  import rpi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [SUM_W-1:0] num_i,
  input  logic signed [SUM_W-1:0] den_i,
  input  rpi_side_t               side_i,
  output logic                    valid_o,
  output rpi_div_t                data_o
);

  // Magnitudes and early rejects: parallel ray, or t strictly negative
  logic signed [SUM_W-1:0] num_abs, den_abs;
  logic [MAG_W-1:0]        nm_q, dm_q;
  logic                    reject_d, reject_q;
  rpi_side_t               side_m_q;
  logic                    valid_m_q;

  always_comb begin
    num_abs  = num_i[SUM_W-1] ? -num_i : num_i;
    den_abs  = den_i[SUM_W-1] ? -den_i : den_i;
    reject_d = (den_i == '0) ||
               ((num_i != '0) && (num_i[SUM_W-1] != den_i[SUM_W-1]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q     <= num_abs[MAG_W-1:0];
      dm_q     <= den_abs[MAG_W-1:0];
      reject_q <= reject_d;
      side_m_q <= side_i;
    end
  end

  // Dividend scaled by the fraction bits; saturate when the quotient
  // would reach 2^T_W
  rpi_div_t         init_d, init_q;
  logic             valid_s_q;
  logic [DIV_W-1:0] den_top;

  always_comb begin
    den_top       = {dm_q, {T_W{1'b0}}};
    init_d.rem    = DIV_W'(nm_q) << FRAC_BITS;
    init_d.den    = dm_q;
    init_d.quo    = '0;
    init_d.sat    = (init_d.rem >= den_top);
    init_d.reject = reject_q;
    init_d.side   = side_m_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_s_q <= 1'b0;
    end else if (en_i) begin
      valid_m_q <= valid_i;
      valid_s_q <= valid_m_q;
    end
  end

  // Quotient bit stages, most significant first
  rpi_div_t chain      [T_W+1];
  logic     chain_valid[T_W+1];

  assign chain[0]       = init_q;
  assign chain_valid[0] = valid_s_q;

  for (genvar i = 0; i < T_W; i++) begin : g_step
    rpi_div_step #(
      .BIT(T_W - 1 - i)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(chain_valid[i]),
      .data_i (chain[i]),
      .valid_o(chain_valid[i+1]),
      .data_o (chain[i+1])
    );
  end

  assign valid_o = chain_valid[T_W];
  assign data_o  = chain[T_W];

endmodule

FILE: src/ray_plane_intersect.sv
// ----------------------------------------------------------------------------
// ray_plane_intersect
// Ray / plane intersection test in signed fixed point:
// t = (plane_offset - origin.normal) / (dir.normal), range checked against
// min_t and the prior closest hit.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------
//  cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o | origin, dir, min_t, prior hit
//  out     | out       | out_valid_o/out_ready_i | hit, update, new_t, material
//
// One transaction per cycle while the output is not stalled; 37 register
// stages lie between an input accept and its valid result: 3 dot-product
// stages, 2 setup stages, 31 divider stages (one per quotient bit) and the
// output register. The divider sets the depth.
// Reset clears all valid bits and loads the register reset values.
// When a result waits at the output the whole pipeline holds; in_ready_o is
// low only while the output register is full and not being taken.
// ----------------------------------------------------------------------------
module ray_plane_intersect
  import rpi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  // ray input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COORD_W-1:0]   origin_x_i,
  input  logic [COORD_W-1:0]   origin_y_i,
  input  logic [COORD_W-1:0]   origin_z_i,
  input  logic [COORD_W-1:0]   dir_x_i,
  input  logic [COORD_W-1:0]   dir_y_i,
  input  logic [COORD_W-1:0]   dir_z_i,
  input  logic [COORD_W-1:0]   min_t_i,
  input  logic                 prior_valid_i,
  input  logic [COORD_W-1:0]   prior_t_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic                 update_o,
  output logic [COORD_W-1:0]   new_t_o,
  output logic [MAT_W-1:0]     hit_material_o
);

  localparam logic [COORD_W-1:0] NORMAL_Y_RST = COORD_W'(1) << FRAC_BITS;

  // Configuration registers
  rpi_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal.x     <= '0;
      cfg_q.normal.y     <= NORMAL_Y_RST;
      cfg_q.normal.z     <= '0;
      cfg_q.plane_offset <= '0;
      cfg_q.material_id  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NORMAL_X:     cfg_q.normal.x     <= cfg_data_i;
        REG_NORMAL_Y:     cfg_q.normal.y     <= cfg_data_i;
        REG_NORMAL_Z:     cfg_q.normal.z     <= cfg_data_i;
        REG_PLANE_OFFSET: cfg_q.plane_offset <= cfg_data_i;
        REG_MATERIAL_ID:  cfg_q.material_id  <= cfg_data_i[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: all stages move together unless the output is blocked
  logic out_valid_q;
  logic advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  rpi_vec_t  origin, dir;
  rpi_side_t side_in;

  assign origin  = '{x: origin_x_i, y: origin_y_i, z: origin_z_i};
  assign dir     = '{x: dir_x_i, y: dir_y_i, z: dir_z_i};
  assign side_in = '{min_t: min_t_i, prior_valid: prior_valid_i, prior_t: prior_t_i};

  // Dot products and sums
  logic                    dot_valid;
  logic signed [SUM_W-1:0] num, den;
  rpi_side_t               dot_side;

  rpi_dot #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .origin_i(origin),
    .dir_i   (dir),
    .side_i  (side_in),
    .cfg_i   (cfg_q),
    .valid_o (dot_valid),
    .num_o   (num),
    .den_o   (den),
    .side_o  (dot_side)
  );

  // Division
  logic     div_valid;
  rpi_div_t div_res;

  rpi_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .valid_i(dot_valid),
    .num_i  (num),
    .den_i  (den),
    .side_i (dot_side),
    .valid_o(div_valid),
    .data_o (div_res)
  );

  // Range checks against min_t and the prior hit
  logic [T_W-1:0]            t_val;
  logic signed [COORD_W-1:0] t_s;
  logic                      below_min, prior_closer;
  logic                      hit_d, update_d;
  logic [COORD_W-1:0]        new_t_d;
  logic [MAT_W-1:0]          mat_d;

  always_comb begin
    t_val        = div_res.sat ? T_MAX : div_res.quo;
    t_s          = {1'b0, t_val};
    below_min    = t_s < $signed(div_res.side.min_t);
    prior_closer = div_res.side.prior_valid && ($signed(div_res.side.prior_t) < t_s);
    hit_d        = !div_res.reject && !below_min;
    update_d     = hit_d && !prior_closer;
    new_t_d      = hit_d ? t_s : '0;
    mat_d        = update_d ? cfg_q.material_id : '0;
  end

  // Output register
  logic               hit_q, update_q;
  logic [COORD_W-1:0] new_t_q;
  logic [MAT_W-1:0]   mat_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q    <= hit_d;
      update_q <= update_d;
      new_t_q  <= new_t_d;
      mat_q    <= mat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= div_valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign update_o       = update_q;
  assign new_t_o        = new_t_q;
  assign hit_material_o = mat_q;

endmodule

FILE: src/rpi_checker.sv
// ----------------------------------------------------------------------------
// rpi_checker
// Port-level checks on the result channel of ray_plane_intersect.
// ----------------------------------------------------------------------------
module rpi_checker
  import rpi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               hit_i,
  input logic               update_i,
  input logic [COORD_W-1:0] new_t_i,
  input logic [MAT_W-1:0]   hit_material_i
);

  // An update is only ever reported for a hit
  a_update_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && update_i |-> hit_i)
    else $error("update without hit");

  // Missed rays carry a zero distance
  a_miss_zero_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> new_t_i == '0)
    else $error("new_t nonzero on a miss");

  // Material is only reported with an update
  a_material_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !update_i |-> hit_material_i == '0)
    else $error("material reported without update");

  // A reported distance is never negative
  a_t_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> !new_t_i[COORD_W-1])
    else $error("negative distance on a hit");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(new_t_i) &&
      $stable(hit_i) && $stable(update_i) && $stable(hit_material_i))
    else $error("result changed while stalled");

endmodule

bind ray_plane_intersect rpi_checker u_rpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_i         (hit_o),
  .update_i      (update_o),
  .new_t_i       (new_t_o),
  .hit_material_i(hit_material_o)
);
